FILE: hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants and types of the packet frame codec.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

    localparam int PACKET_BYTES = 12;
    localparam int IDX_W        = $clog2(PACKET_BYTES);
    localparam int NIB_W        = 4;

    localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(PACKET_BYTES - 1);
    localparam logic [NIB_W-1:0] PTR_MAX  = NIB_W'(PACKET_BYTES - 2);

    localparam logic [7:0] END_MARK   = 8'hEE;
    localparam logic [7:0] HI_NIB     = 8'hF0;
    localparam logic [7:0] LO_NIB     = 8'h0F;
    localparam logic [7:0] IDENT_BIT  = 8'h04;
    localparam logic [7:0] PARITY_BIT = 8'h08;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef logic [PACKET_BYTES-1:0][7:0] t_bytes;

    typedef struct packed {
        logic       opcode;
        logic       ident_in;
        logic [7:0] in_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       frame_error;
        logic       ident_out;
    } t_out_req;

    typedef struct packed {
        logic   mode;
        logic   ident;
        t_bytes bytes;
    } t_pkt;

    typedef struct packed {
        logic valid;
        t_pkt pkt;
    } t_pkt_xfer;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ENC_SCAN,
        BK_ENC_PAR,
        BK_DEC_CHECK,
        BK_DEC_WALK,
        BK_DEC_FIX,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

FILE: hdl/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Collects the bytes of one packet and hands the full packet to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  pfc_pkg::t_in_req  i_in_req,
    output logic              o_in_stall,
    input  wire               i_q_full,
    output pfc_pkg::t_pkt_xfer o_push
);
    import pfc_pkg::*;

    logic [IDX_W-1:0] r_pos;
    logic             r_mode;
    logic             r_ident;
    t_bytes           r_bytes;
    logic             w_accept;
    logic             w_at_last;

    assign w_at_last  = (r_pos == POS_LAST);
    // Only the closing byte needs room in the queue.
    assign o_in_stall = w_at_last && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        o_push.valid              = w_accept && w_at_last;
        o_push.pkt.mode           = r_mode;
        o_push.pkt.ident          = r_ident;
        o_push.pkt.bytes          = r_bytes;
        o_push.pkt.bytes[POS_LAST] = i_in_req.in_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_mode  <= 1'b0;
            r_ident <= 1'b0;
        end else if (w_accept) begin
            if (w_at_last) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + IDX_W'(1);
            end
            if (r_pos == '0) begin
                r_mode  <= i_in_req.opcode;
                r_ident <= i_in_req.ident_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bytes[r_pos] <= i_in_req.in_byte;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue
// Two-entry packet queue between the collector and the processing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  pfc_pkg::t_pkt_xfer i_push,
    output logic               o_full,
    input  wire                i_pop,
    output pfc_pkg::t_pkt_xfer o_head
);
    import pfc_pkg::*;

    t_pkt       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_full      = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.pkt   = r_mem[r_rd];
    assign w_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push.valid && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push.valid && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.pkt;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// Encodes or decodes one queued packet step by step, then emits its bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  pfc_pkg::t_pkt_xfer i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    output pfc_pkg::t_out_req  o_out_req,
    input  wire                i_out_stall
);
    import pfc_pkg::*;

    t_back_state      r_state, n_state;
    t_bytes           r_work,  n_work;
    logic [NIB_W-1:0] r_idx,   n_idx;
    logic [NIB_W-1:0] r_prev,  n_prev;
    logic [NIB_W-1:0] r_link,  n_link;
    logic [IDX_W-1:0] r_cnt,   n_cnt;
    logic             r_err,   n_err;
    logic             r_ident, n_ident;
    logic             r_oid,   n_oid;
    logic [7:0]       w_cur;
    logic [NIB_W-1:0] w_cur_ptr;
    logic             w_parity;

    assign w_cur     = r_work[r_idx[IDX_W-1:0]];
    assign w_cur_ptr = w_cur[7:4];
    assign w_parity  = ^r_work;

    assign o_out_valid           = (r_state == BK_EMIT);
    assign o_out_req.out_byte    = r_work[0];
    assign o_out_req.last_byte   = (r_cnt == POS_LAST);
    assign o_out_req.frame_error = r_err;
    assign o_out_req.ident_out   = r_oid;

    always_comb begin
        n_state = r_state;
        n_work  = r_work;
        n_idx   = r_idx;
        n_prev  = r_prev;
        n_link  = r_link;
        n_cnt   = r_cnt;
        n_err   = r_err;
        n_ident = r_ident;
        n_oid   = r_oid;
        o_pop   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_work  = i_head.pkt.bytes;
                    n_ident = i_head.pkt.ident;
                    n_err   = 1'b0;
                    n_cnt   = '0;
                    if (i_head.pkt.mode == OP_ENCODE) begin
                        n_work[0] = i_head.pkt.bytes[0]
                                    | (i_head.pkt.ident ? IDENT_BIT : 8'h00);
                        n_work[POS_LAST] = END_MARK;
                        n_idx   = NIB_W'(1);
                        n_link  = '0;
                        n_state = BK_ENC_SCAN;
                    end else begin
                        n_state = BK_DEC_CHECK;
                    end
                end
            end
            BK_ENC_SCAN: begin
                if (w_cur == END_MARK) begin
                    n_work[r_idx[IDX_W-1:0]] = 8'h00;
                    if (r_link == '0) begin
                        n_work[0] = r_work[0] | {r_idx, 4'h0};
                    end else begin
                        n_work[r_link[IDX_W-1:0]] = {r_idx, 4'h0};
                    end
                    n_link = r_idx;
                end
                if (r_idx == PTR_MAX) begin
                    n_state = BK_ENC_PAR;
                end else begin
                    n_idx = r_idx + NIB_W'(1);
                end
            end
            BK_ENC_PAR: begin
                if (w_parity) begin
                    n_work[0] = r_work[0] ^ PARITY_BIT;
                end
                n_oid   = r_ident;
                n_state = BK_EMIT;
            end
            BK_DEC_CHECK: begin
                if (w_parity || (r_work[POS_LAST] != END_MARK)) begin
                    n_err   = 1'b1;
                    n_oid   = 1'b0;
                    n_state = BK_EMIT;
                end else begin
                    n_idx   = r_work[0][7:4];
                    n_prev  = '0;
                    n_state = BK_DEC_WALK;
                end
            end
            BK_DEC_WALK: begin
                if (r_idx == '0) begin
                    n_idx   = r_work[0][7:4];
                    n_state = BK_DEC_FIX;
                end else if ((r_idx <= r_prev) || (r_idx > PTR_MAX)) begin
                    n_err   = 1'b1;
                    n_oid   = 1'b0;
                    n_state = BK_EMIT;
                end else begin
                    n_prev = r_idx;
                    n_idx  = w_cur_ptr;
                end
            end
            BK_DEC_FIX: begin
                if (r_idx == '0) begin
                    n_oid   = |(r_work[0] & IDENT_BIT);
                    n_state = BK_EMIT;
                end else begin
                    n_work[r_idx[IDX_W-1:0]] = END_MARK;
                    n_idx = w_cur_ptr;
                end
            end
            BK_EMIT: begin
                if (!i_out_stall) begin
                    n_work = r_work >> 8;
                    if (r_cnt == POS_LAST) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_cnt = r_cnt + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_idx   <= n_idx;
        r_prev  <= n_prev;
        r_link  <= n_link;
        r_err   <= n_err;
        r_ident <= n_ident;
        r_oid   <= n_oid;
    end

endmodule

`default_nettype wire

FILE: hdl/packet_frame_codec.sv
// ----------------------------------------------------------------------------
// packet_frame_codec
// Fixed-length packet framer: pointer-chain byte stuffing with even parity.
// ----------------------------------------------------------------------------
// The input channel carries one packet byte per request, positions 0 to 11
// in order. The opcode (encode or decode) and the identifier bit are taken
// from the request at position 0. No result appears until the twelfth byte
// of a packet has been taken; then the packet is processed and twelve result
// requests follow on the output channel, the last one flagged by last_byte.
// A collector gathers bytes into a holding register, a two-entry packet
// queue decouples it from the processing engine, and the engine works on
// one packet at a time. Encoding runs a load step, a pointer scan over
// positions 1 to 10 and a parity step; decoding runs a load step, a check
// step, then the chain check and the restore walk, and stops early on a
// bad frame. The engine takes a new packet from the queue only after the
// last result request of the previous packet has been taken.
// While the engine works, the collector keeps taking the next packets until
// the queue is full; it then stalls only on the closing byte of a packet.
// A stalled output holds its request; the engine simply waits. Reset empties
// the queue, returns the collector to position 0 and idles the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_frame_codec (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  pfc_pkg::t_in_req  i_in_req,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output pfc_pkg::t_out_req o_out_req,
    input  wire               i_out_stall
);
    import pfc_pkg::*;

    t_pkt_xfer w_push;
    t_pkt_xfer w_head;
    logic      w_full;
    logic      w_pop;

    // Collector: assembles one packet, latching mode and identifier.
    pfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    // Packet queue: lets the collector run ahead of the engine.
    pfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Engine: pointer scan, parity, chain check and restore, byte output.
    pfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

FILE: hdl/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks of the packet frame codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input pfc_pkg::t_in_req  i_in_req,
    input wire               o_in_stall,
    input wire               o_out_valid,
    input pfc_pkg::t_out_req o_out_req,
    input wire               i_out_stall
);

    // A stalled input request holds its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_req)))
        else $error("input request changed while stalled");

    // A stalled result request holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_req)))
        else $error("output request changed while stalled");

    // A failed decode never reports an identifier.
    a_err_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.frame_error) |-> !o_out_req.ident_out)
        else $error("identifier reported with frame error");

    // Status flags stay constant across the bytes of one packet.
    a_flags_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_req.last_byte) |=>
        (o_out_valid && $stable(o_out_req.frame_error)
         && $stable(o_out_req.ident_out)))
        else $error("packet status changed mid-packet");

    // No result leaves the block in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind packet_frame_codec pfc_checker u_pfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_req    (i_in_req),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_req   (o_out_req),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet frame codec.
// ----------------------------------------------------------------------------
// Whole packets are sent one byte per request. Each accepted input request
// goes through a local model of the collector and the encode/decode engine.
// When a packet is complete, that model queues the twelve result requests it
// predicts. A few directed packets carry hand-written results instead. Each
// accepted output request is then checked field by field against the oldest
// queued result. The run is split into phases with different sender and
// receiver idling; each phase sends some directed packets, then a random
// one. It ends with a long receiver hold-off that backs up the packet queue
// and stalls the input.
// ----------------------------------------------------------------------------
module tb_top;
    import pfc_pkg::*;

    // The slowest legal quiet stretch is the receiver hold-off plus one engine
    // pass and a few random stalls. A stretch as long as the watchdog limit
    // with no request taken on either side is therefore a hang.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PKTS_PER_PHASE = 1;
    localparam int DIR_PER_PHASE  = 2;
    localparam int NUM_DIR        = 12;
    localparam int NUM_PHASES     = 4;

    // Idling per phase, in percent of cycles: none, sender, receiver, both.
    localparam logic [NUM_PHASES-1:0][7:0] SND_IDLE = {8'd6, 8'd0, 8'd47, 8'd0};
    localparam logic [NUM_PHASES-1:0][7:0] RCV_IDLE = {8'd6, 8'd47, 8'd0, 8'd0};

    // Outcome of one packet. When "typed" is set, the fields were written by
    // hand and replace what the local model computes.
    typedef struct packed {
        logic   typed;
        t_bytes bytes;
        logic   err;
        logic   ident;
    } t_frame_result;

    typedef struct packed {
        logic          opcode;
        logic          ident;
        t_bytes        bytes;
        t_frame_result want;
    } t_frame_case;

    // Ways of damaging a well-formed frame before it is sent for decoding.
    typedef enum logic [1:0] {
        CUT_BIT,
        CUT_END,
        CUT_LINK
    } t_frame_cut;

    localparam t_frame_result PREDICTED = '0;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_in_req  in_req    = '0;
    logic     in_stall;
    logic     out_valid;
    t_out_req out_req;
    logic     out_stall = 1'b0;

    // Local copy of the codec state, advanced on every accepted input request.
    t_bytes        pkt_store;
    int            pkt_pos   = 0;
    logic          pkt_mode  = OP_ENCODE;
    logic          pkt_ident = 1'b0;

    t_out_req      byte_exp_q[$];   // result requests still to arrive
    t_frame_result plan_q[$];       // one entry per packet being sent
    int            err_cnt      = 0;
    int            quiet_cycles = 0;

    int            snd_idle_pct  = 0;
    int            rcv_stall_pct = 0;
    logic          hold_tgl      = 1'b0;
    logic          hold_seen     = 1'b0;
    int            hold_left     = 0;

    t_frame_case   dir_cases [NUM_DIR];

    always #5 clk = ~clk;

    packet_frame_codec DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_req   (out_req),
        .i_out_stall (out_stall)
    );

    // Encoding: the identifier is ORed into byte 0, the end mark is written at
    // the last position, and every end mark in the payload becomes a link of
    // the pointer chain. Bit 3 of byte 0 then makes the overall parity even.
    function automatic t_bytes frame_encode(t_bytes raw, logic id);
        t_bytes b;
        int     link;
        b    = raw;
        link = 0;
        if (id)
            b[0] = b[0] | IDENT_BIT;
        b[PACKET_BYTES-1] = END_MARK;
        for (int pos = 1; pos < PACKET_BYTES - 1; pos++) begin
            if (b[pos] == END_MARK) begin
                b[pos]  = 8'h00;
                b[link] = b[link] | 8'(pos << 4);
                link    = pos;
            end
        end
        if (^b)
            b[0] = b[0] ^ PARITY_BIT;
        return b;
    endfunction

    // Decoding: bad parity, a missing end mark, or a chain link that does not
    // move forward or runs past the last payload byte is a frame error. The
    // bytes then pass unchanged. Otherwise the chain is walked and each
    // visited position gets its end mark back. Byte 0 is passed as received.
    function automatic t_frame_result frame_decode(t_bytes raw);
        t_frame_result r;
        int            prev;
        int            ptr;
        int            nxt;
        r.typed = 1'b0;
        r.bytes = raw;
        r.err   = 1'b1;
        r.ident = 1'b0;
        if (^raw || raw[PACKET_BYTES-1] != END_MARK)
            return r;
        prev = 0;
        ptr  = raw[0][7:4];
        for (int n = 0; n < 16 && ptr != 0; n++) begin
            if (ptr <= prev || ptr > PACKET_BYTES - 2)
                return r;
            prev = ptr;
            ptr  = raw[ptr][7:4];
        end
        ptr = raw[0][7:4];
        for (int n = 0; n < 16 && ptr != 0; n++) begin
            nxt          = r.bytes[ptr][7:4];
            r.bytes[ptr] = END_MARK;
            ptr          = nxt;
        end
        r.err   = 1'b0;
        r.ident = (raw[0] & IDENT_BIT) != 8'h00;
        return r;
    endfunction

    // Takes one accepted input request. On the closing byte of a packet, it
    // queues the twelve result requests that the packet should produce.
    task automatic codec_take(t_in_req r);
        t_frame_result res;
        t_frame_result plan;
        t_out_req      o;
        if (pkt_pos == 0) begin
            pkt_mode  = r.opcode;
            pkt_ident = r.ident_in;
        end
        pkt_store[pkt_pos] = r.in_byte;
        if (pkt_pos < PACKET_BYTES - 1) begin
            pkt_pos++;
            return;
        end
        pkt_pos = 0;
        if (pkt_mode == OP_ENCODE) begin
            res.typed = 1'b0;
            res.bytes = frame_encode(pkt_store, pkt_ident);
            res.err   = 1'b0;
            res.ident = pkt_ident;
        end else begin
            res = frame_decode(pkt_store);
        end
        pkt_store  = res.bytes;
        plan.typed = 1'b0;
        if (plan_q.size() != 0)
            plan = plan_q.pop_front();
        if (plan.typed)
            res = plan;
        for (int k = 0; k < PACKET_BYTES; k++) begin
            o.out_byte    = res.bytes[k];
            o.last_byte   = (k == PACKET_BYTES - 1);
            o.frame_error = res.err;
            o.ident_out   = res.ident;
            byte_exp_q.push_back(o);
        end
    endtask

    // Both channels are sampled at the rising edge, so the values seen here
    // are the ones that were present during the cycle that just ended.
    always @(posedge clk) begin : result_check
        t_out_req want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (byte_exp_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with none pending: byte %h last %b err %b ident %b",
                             $time, out_req.out_byte, out_req.last_byte,
                             out_req.frame_error, out_req.ident_out);
                end else begin
                    want = byte_exp_q.pop_front();
                    if (want.out_byte !== out_req.out_byte ||
                        want.last_byte !== out_req.last_byte ||
                        want.frame_error !== out_req.frame_error ||
                        want.ident_out !== out_req.ident_out) begin
                        err_cnt++;
                        $display("%0t: expected byte %h last %b err %b ident %b",
                                 $time, want.out_byte, want.last_byte,
                                 want.frame_error, want.ident_out);
                        $display("%0t:   actual byte %h last %b err %b ident %b",
                                 $time, out_req.out_byte, out_req.last_byte,
                                 out_req.frame_error, out_req.ident_out);
                    end
                end
            end
            if (in_valid && !in_stall)
                codec_take(in_req);
        end
    end

    // Watchdog: counts cycles in which no request is taken on either side.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver. A toggle of hold_tgl starts a long hold-off, counted here.
    // Otherwise the receiver stalls at random at the rate of the phase.
    always @(posedge clk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // Offers one request and returns at the edge where it is taken. Valid is
    // left high, so the next request can follow without a gap. The caller
    // lowers valid when it stops sending.
    task automatic send_byte(t_in_req r);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Opcode and identifier matter only on the first byte. On the other bytes
    // they are random, to show that the block ignores them there.
    task automatic send_packet(logic op, logic id, t_bytes b, t_frame_result plan);
        t_in_req r;
        plan_q.push_back(plan);
        for (int k = 0; k < PACKET_BYTES; k++) begin
            r.opcode   = (k == 0) ? op : 1'($urandom);
            r.ident_in = (k == 0) ? id : 1'($urandom);
            r.in_byte  = b[k];
            send_byte(r);
        end
    endtask

    // Most random packets are encodes, or decodes of frames that are well
    // formed, so that the chain walk and the restore are exercised. Payloads
    // hold many end marks to make long chains. The rest are damaged frames
    // and pure noise.
    task automatic make_random_packet(output logic op, output logic id, output t_bytes b);
        t_bytes     body;
        int         kind;
        int         p;
        int         q;
        t_frame_cut cut;
        for (int k = 0; k < PACKET_BYTES; k++)
            body[k] = ($urandom_range(3) == 0) ? END_MARK : 8'($urandom);
        id   = 1'($urandom);
        kind = $urandom_range(9);
        p    = $urandom_range(PACKET_BYTES - 1);
        q    = $urandom_range(7);
        if (kind < 4) begin
            op = OP_ENCODE;
            b  = body;
        end else if (kind < 9) begin
            op = OP_DECODE;
            b  = frame_encode(body, id);
            id = 1'($urandom);
            if (kind == 8) begin
                cut = t_frame_cut'($urandom_range(2));
                case (cut)
                    CUT_BIT: begin
                        b[p][q] = ~b[p][q];
                    end
                    CUT_END: begin
                        b[PACKET_BYTES-1] = 8'($urandom);
                        if (^b)
                            b[0] = b[0] ^ PARITY_BIT;
                    end
                    default: begin
                        b[p % (PACKET_BYTES - 1)][7:4] = 4'($urandom);
                        if (^b)
                            b[0] = b[0] ^ PARITY_BIT;
                    end
                endcase
            end
        end else begin
            op = OP_DECODE;
            for (int k = 0; k < PACKET_BYTES; k++)
                b[k] = 8'($urandom);
            if ($urandom_range(1) == 1)
                b[PACKET_BYTES-1] = END_MARK;
            if ($urandom_range(1) == 1 && ^b)
                b[0] = b[0] ^ PARITY_BIT;
        end
    endtask

    initial begin : stimulus
        logic   op;
        logic   id;
        t_bytes b;

        // Directed packets. Bytes are written from position 11 down to 0.
        // Where the outcome is obvious, it is written out by hand.
        // Encode of all zeros: only the end mark, parity already even.
        dir_cases[0]  = {OP_ENCODE, 1'b0, 96'h0,
                         1'b1, 96'hEE_00_00_00_00_00_00_00_00_00_00_00, 1'b0, 1'b0};
        // Encode with the identifier set. The last input byte is overwritten,
        // and the parity bit joins the identifier in byte 0.
        dir_cases[1]  = {OP_ENCODE, 1'b1, 96'hFF_00_00_00_00_00_00_00_00_00_00_00,
                         1'b1, 96'hEE_00_00_00_00_00_00_00_00_00_00_0C, 1'b0, 1'b1};
        // Encode with end marks at the first and last payload positions and at 4.
        dir_cases[2]  = {OP_ENCODE, 1'b0, 96'hFF_EE_FF_FF_FF_FF_FF_EE_FF_FF_EE_03,
                         PREDICTED};
        // Decode of a good two-link chain. Byte 0 comes back as received.
        dir_cases[3]  = {OP_DECODE, 1'b0, 96'hEE_00_00_00_05_00_00_00_70_00_00_34,
                         PREDICTED};
        // Decode with odd parity: frame error, bytes unchanged.
        dir_cases[4]  = {OP_DECODE, 1'b0, 96'hEE_00_00_00_00_00_01_00_00_00_00_00,
                         1'b1, 96'hEE_00_00_00_00_00_01_00_00_00_00_00, 1'b1, 1'b0};
        // Decode with a wrong end byte but even parity.
        dir_cases[5]  = {OP_DECODE, 1'b0, 96'hED_00_00_00_00_00_00_00_00_00_00_00,
                         1'b1, 96'hED_00_00_00_00_00_00_00_00_00_00_00, 1'b1, 1'b0};
        // Decode with a chain that steps backward.
        dir_cases[6]  = {OP_DECODE, 1'b0, 96'hEE_00_00_00_00_00_30_00_00_00_00_50,
                         1'b1, 96'hEE_00_00_00_00_00_30_00_00_00_00_50, 1'b1, 1'b0};
        // Decode with the first pointer beyond the last payload byte.
        dir_cases[7]  = {OP_DECODE, 1'b1, 96'hEE_00_00_00_00_00_00_00_00_00_00_B8,
                         1'b1, 96'hEE_00_00_00_00_00_00_00_00_00_00_B8, 1'b1, 1'b0};
        // Decode with a link that points to itself.
        dir_cases[8]  = {OP_DECODE, 1'b0, 96'hEE_00_00_00_00_00_00_00_00_20_00_20,
                         1'b1, 96'hEE_00_00_00_00_00_00_00_00_20_00_20, 1'b1, 1'b0};
        // Decode with a pointer to the last payload byte, which is legal.
        dir_cases[9]  = {OP_DECODE, 1'b1, 96'hEE_05_00_00_00_00_00_00_00_00_00_A0,
                         PREDICTED};
        // Decode of all ones: parity and end byte are fine, the chain is not.
        dir_cases[10] = {OP_DECODE, 1'b0, 96'hEE_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF,
                         1'b1, 96'hEE_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b1, 1'b0};
        // Encode of all ones with the identifier set.
        dir_cases[11] = {OP_ENCODE, 1'b1, 96'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF,
                         PREDICTED};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            snd_idle_pct   = SND_IDLE[ph];
            rcv_stall_pct <= RCV_IDLE[ph];
            for (int i = ph * DIR_PER_PHASE; i < (ph + 1) * DIR_PER_PHASE; i++)
                send_packet(dir_cases[i].opcode, dir_cases[i].ident,
                            dir_cases[i].bytes, dir_cases[i].want);
            repeat (PKTS_PER_PHASE) begin
                make_random_packet(op, id, b);
                send_packet(op, id, b, PREDICTED);
            end
            in_valid <= 1'b0;
            // The plan queue covers the edge where the closing byte was just
            // taken and its results are not queued yet.
            while (byte_exp_q.size() != 0 || plan_q.size() != 0)
                @(posedge clk);
        end

        // Back pressure: the receiver holds off while the remaining directed
        // packets keep coming, so the packet queue fills and the input stalls
        // on a closing byte.
        snd_idle_pct   = 0;
        rcv_stall_pct <= 0;
        hold_tgl      <= ~hold_tgl;
        for (int i = NUM_PHASES * DIR_PER_PHASE; i < NUM_DIR; i++)
            send_packet(dir_cases[i].opcode, dir_cases[i].ident,
                        dir_cases[i].bytes, dir_cases[i].want);
        in_valid <= 1'b0;
        while (byte_exp_q.size() != 0 || plan_q.size() != 0)
            @(posedge clk);

        // Let any stray output show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && byte_exp_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pfc_pkg.sv
hdl/pfc_front.sv
hdl/pfc_queue.sv
hdl/pfc_back.sv
hdl/packet_frame_codec.sv
hdl/pfc_checker.sv
dv/tb_top.sv
